>>> src/rart_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and arithmetic helpers for the range-add / range-max table.
// Used by rart_cell, range_add_range_max_table and rart_checker; depends on nothing.
package rart_pkg;

  localparam int MAX_ENTRIES  = 1024;
  localparam int VALUE_BITS   = 48;
  localparam int OPERAND_BITS = 32;
  localparam int NUM_CELLS    = 32;
  localparam int CELL_DEPTH   = MAX_ENTRIES / NUM_CELLS;
  localparam int IDX_BITS     = $clog2(MAX_ENTRIES);
  localparam int SIZE_BITS    = IDX_BITS + 1;
  localparam int ADDR_BITS    = $clog2(CELL_DEPTH);
  localparam int CELL_BITS    = $clog2(NUM_CELLS);
  localparam int OP_BITS      = 2;

  typedef logic [OP_BITS-1:0] op_t;
  localparam op_t OP_ASSIGN = 2'd0;
  localparam op_t OP_ADD    = 2'd1;
  localparam op_t OP_QUERY  = 2'd2;

  typedef logic signed [VALUE_BITS-1:0]   value_t;
  typedef logic signed [OPERAND_BITS-1:0] operand_t;

  localparam value_t VAL_MAX   = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam value_t VAL_MIN   = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam value_t EMPTY_MAX = VALUE_BITS'(-64'sd1000000000);

  // One operation as it travels down the row of cells.
  typedef struct packed {
    op_t                 op;
    logic [IDX_BITS-1:0] lo;
    logic [IDX_BITS-1:0] hi;
    operand_t            val;
    logic                err;
    logic                empty;
  } cmd_t;

  // Neighbor-to-neighbor hand-off: start pulse, the operation and the running maximum.
  typedef struct packed {
    logic   go;
    cmd_t   cmd;
    value_t chain;
  } link_t;

  typedef struct packed {
    logic   busy;
    logic   fin;
    value_t fin_max;
  } stat_t;

  function automatic value_t sext_operand(operand_t b);
    return {{(VALUE_BITS-OPERAND_BITS){b[OPERAND_BITS-1]}}, b};
  endfunction

  function automatic value_t sat_add(value_t a, operand_t b);
    logic [VALUE_BITS:0] sum;
    value_t              res;
    sum = {a[VALUE_BITS-1], a} + {{(VALUE_BITS+1-OPERAND_BITS){b[OPERAND_BITS-1]}}, b};
    if (sum[VALUE_BITS] != sum[VALUE_BITS-1]) begin
      res = sum[VALUE_BITS] ? VAL_MIN : VAL_MAX;
    end else begin
      res = sum[VALUE_BITS-1:0];
    end
    return res;
  endfunction

  function automatic value_t max_of(value_t a, value_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

>>> src/range_add_range_max_table.sv
`timescale 1ns / 1ps
// Top level of the range-add / range-max table: input checks, size register, the row of
// rart_cell slices and the result register. Uses rart_pkg and rart_cell.
//
// Use: a command (opcode, low_index, high_index, operand_value) transfers at a rising edge
// with start high and busy low. Opcode 0 assigns one entry, 1 adds a signed value to every
// entry of an inclusive index range (saturating at 48 bits), 2 returns the range maximum.
// Every command gives exactly one result: out_strobe is high for one cycle with
// out_max_value, out_empty_range and out_index_error. The receiver cannot stall; a result
// is taken in the cycle it is shown.
// The 1024 entries are spread over 32 cells of 32 entries. A command enters cell 0 and
// moves one cell per clock; each cell sweeps its 32 entries with one memory read and one
// write per cycle, and passes its running maximum to its right neighbor.
// A new command is taken only once cell 0 has finished sweeping the previous one; busy is
// high during that sweep. out_strobe rises after the command has crossed the 32-cell row
// and the last cell's sweep, plus the result register; a later command may enter before that.
// cfg_data writes the active size on a cfg_valid transfer (cfg_ready is always high); the
// user must write it only while no command is in flight; the block does not enforce it.
// Reset sets the size to 1024, then each cell zeroes its 32 entries; busy stays high until done.
module range_add_range_max_table (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [rart_pkg::OP_BITS-1:0]          in_opcode,
  input  logic [rart_pkg::IDX_BITS-1:0]         in_low_index,
  input  logic [rart_pkg::IDX_BITS-1:0]         in_high_index,
  input  logic signed [rart_pkg::OPERAND_BITS-1:0] in_operand_value,
  output logic                                  out_strobe,
  output logic signed [rart_pkg::VALUE_BITS-1:0] out_max_value,
  output logic                                  out_empty_range,
  output logic                                  out_index_error,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rart_pkg::SIZE_BITS-1:0]        cfg_data
);

  logic [rart_pkg::SIZE_BITS-1:0] size_r;
  logic [rart_pkg::SIZE_BITS-1:0] size_nxt;
  logic                           out_strobe_r;
  rart_pkg::value_t               out_max_r;
  rart_pkg::value_t               out_max_nxt;
  logic                           out_empty_r;
  logic                           out_err_r;

  logic                           lo_bad;
  logic                           hi_bad;
  logic                           is_range_op;
  rart_pkg::link_t                front_link;
  rart_pkg::link_t                link_w [rart_pkg::NUM_CELLS+1];
  rart_pkg::stat_t                stat_w [rart_pkg::NUM_CELLS];
  rart_pkg::cmd_t                 last_cmd;
  rart_pkg::stat_t                last_stat;

  assign cfg_ready = 1'b1;
  assign busy      = stat_w[0].busy;

  always_comb begin
    size_nxt = cfg_data;
    if (cfg_data == '0) begin
      size_nxt = rart_pkg::SIZE_BITS'(1);
    end else if (cfg_data > rart_pkg::SIZE_BITS'(rart_pkg::MAX_ENTRIES)) begin
      size_nxt = rart_pkg::SIZE_BITS'(rart_pkg::MAX_ENTRIES);
    end
  end

  always_comb begin
    lo_bad      = {1'b0, in_low_index} >= size_r;
    hi_bad      = {1'b0, in_high_index} >= size_r;
    is_range_op = (in_opcode == rart_pkg::OP_ADD) || (in_opcode == rart_pkg::OP_QUERY);

    front_link.go        = start && !busy;
    front_link.cmd.op    = in_opcode;
    front_link.cmd.lo    = in_low_index;
    front_link.cmd.hi    = in_high_index;
    front_link.cmd.val   = in_operand_value;
    front_link.cmd.err   = ((in_opcode == rart_pkg::OP_ASSIGN) && lo_bad) ||
                           (is_range_op && (lo_bad || hi_bad));
    front_link.cmd.empty = is_range_op && !lo_bad && !hi_bad &&
                           (in_low_index > in_high_index);
    front_link.chain     = rart_pkg::VAL_MIN;
  end

  assign link_w[0] = front_link;

  for (genvar k = 0; k < rart_pkg::NUM_CELLS; k++) begin : g_cell
    rart_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_id  (rart_pkg::CELL_BITS'(k)),
      .link_in  (link_w[k]),
      .link_out (link_w[k+1]),
      .stat     (stat_w[k])
    );
  end

  // The last cell still holds the finishing command during its final sweep cycle.
  always_comb begin
    last_cmd  = link_w[rart_pkg::NUM_CELLS].cmd;
    last_stat = stat_w[rart_pkg::NUM_CELLS-1];
    out_max_nxt = '0;
    if (last_cmd.err) begin
      out_max_nxt = '0;
    end else if (last_cmd.empty) begin
      out_max_nxt = (last_cmd.op == rart_pkg::OP_QUERY) ? rart_pkg::EMPTY_MAX : '0;
    end else if (last_cmd.op == rart_pkg::OP_QUERY) begin
      out_max_nxt = last_stat.fin_max;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r       <= rart_pkg::SIZE_BITS'(rart_pkg::MAX_ENTRIES);
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_r <= size_nxt;
      end
      out_strobe_r <= last_stat.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (last_stat.fin) begin
      out_max_r   <= out_max_nxt;
      out_empty_r <= last_cmd.empty;
      out_err_r   <= last_cmd.err;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_max_value   = out_max_r;
  assign out_empty_range = out_empty_r;
  assign out_index_error = out_err_r;

endmodule

>>> src/rart_cell.sv
`timescale 1ns / 1ps
// One cell of the table: a slice of CELL_DEPTH entries in a local memory, swept once per
// operation, with the running range maximum handed on to the next cell. Uses rart_pkg.
module rart_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [rart_pkg::CELL_BITS-1:0] cell_id,
  input  rart_pkg::link_t                link_in,
  output rart_pkg::link_t                link_out,
  output rart_pkg::stat_t                stat
);

  rart_pkg::value_t                   mem [rart_pkg::CELL_DEPTH];
  logic                               clr_r;
  rart_pkg::cmd_t                     cmd_q_r;
  logic                               go_r;
  logic                               act_r;
  logic [rart_pkg::ADDR_BITS-1:0]     cnt_r;
  logic                               rv_r;
  logic [rart_pkg::ADDR_BITS-1:0]     ra_r;
  rart_pkg::value_t                   rdata_r;
  rart_pkg::value_t                   lmax_r;
  rart_pkg::value_t                   lmax_nxt;
  rart_pkg::value_t                   chain_r;
  rart_pkg::value_t                   chain_nxt;

  logic [rart_pkg::IDX_BITS-1:0]      idx;
  rart_pkg::value_t                   entry;
  logic                               in_range;
  logic                               do_assign;
  logic                               do_add;
  logic                               do_max;
  logic                               wr_en;
  rart_pkg::value_t                   wr_data;
  logic                               fin;

  always_comb begin
    idx       = {cell_id, ra_r};
    entry     = rdata_r;
    in_range  = (idx >= cmd_q_r.lo) && (idx <= cmd_q_r.hi);
    do_assign = rv_r && (cmd_q_r.op == rart_pkg::OP_ASSIGN) && !cmd_q_r.err &&
                (idx == cmd_q_r.lo);
    do_add    = rv_r && (cmd_q_r.op == rart_pkg::OP_ADD) && !cmd_q_r.err &&
                !cmd_q_r.empty && in_range;
    do_max    = rv_r && (cmd_q_r.op == rart_pkg::OP_QUERY) && !cmd_q_r.err &&
                !cmd_q_r.empty && in_range;
    wr_en     = do_assign || do_add;
    wr_data   = do_assign ? rart_pkg::sext_operand(cmd_q_r.val)
                          : rart_pkg::sat_add(entry, cmd_q_r.val);
    lmax_nxt  = do_max ? rart_pkg::max_of(lmax_r, entry) : lmax_r;
    fin       = rv_r && (ra_r == rart_pkg::ADDR_BITS'(rart_pkg::CELL_DEPTH - 1));
    // The left neighbor finished in the cycle before, so its maximum is already registered.
    chain_nxt = rart_pkg::max_of(link_in.chain, lmax_nxt);
  end

  always_ff @(posedge clk) begin
    if (act_r) begin
      rdata_r <= mem[cnt_r];
    end
    // After reset the counter walks every address once and zeroes it.
    if (clr_r) begin
      mem[cnt_r] <= '0;
    end else if (wr_en) begin
      mem[ra_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
      go_r  <= 1'b0;
      act_r <= 1'b0;
      cnt_r <= '0;
      rv_r  <= 1'b0;
    end else begin
      go_r <= link_in.go;
      rv_r <= act_r;
      if (clr_r) begin
        cnt_r <= cnt_r + rart_pkg::ADDR_BITS'(1);
        if (cnt_r == rart_pkg::ADDR_BITS'(rart_pkg::CELL_DEPTH - 1)) begin
          clr_r <= 1'b0;
        end
      end else if (link_in.go) begin
        act_r <= 1'b1;
        cnt_r <= '0;
      end else if (act_r) begin
        cnt_r <= cnt_r + rart_pkg::ADDR_BITS'(1);
        if (cnt_r == rart_pkg::ADDR_BITS'(rart_pkg::CELL_DEPTH - 1)) begin
          act_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ra_r <= cnt_r;
    if (link_in.go) begin
      cmd_q_r <= link_in.cmd;
      lmax_r  <= rart_pkg::VAL_MIN;
    end else begin
      lmax_r  <= lmax_nxt;
    end
    if (fin) begin
      chain_r <= chain_nxt;
    end
  end

  assign link_out.go    = go_r;
  assign link_out.cmd   = cmd_q_r;
  assign link_out.chain = chain_r;

  assign stat.busy    = act_r || clr_r;
  assign stat.fin     = fin;
  assign stat.fin_max = chain_nxt;

endmodule

>>> src/rart_checker.sv
`timescale 1ns / 1ps
// Port-level checks for range_add_range_max_table, attached with a bind statement.
// Uses rart_pkg; sees only the top-level ports.
module rart_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   start,
  input logic                                   busy,
  input logic [rart_pkg::OP_BITS-1:0]           in_opcode,
  input logic [rart_pkg::IDX_BITS-1:0]          in_low_index,
  input logic [rart_pkg::IDX_BITS-1:0]          in_high_index,
  input logic signed [rart_pkg::OPERAND_BITS-1:0] in_operand_value,
  input logic                                   out_strobe,
  input logic signed [rart_pkg::VALUE_BITS-1:0] out_max_value,
  input logic                                   out_empty_range,
  input logic                                   out_index_error,
  input logic                                   cfg_valid,
  input logic                                   cfg_ready,
  input logic [rart_pkg::SIZE_BITS-1:0]         cfg_data
);

  // A transfer on the command side always occupies the block for the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after a command transfer");

  // Commands are at least a full sweep apart, so results never come back to back.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two results in consecutive cycles");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_empty_range && out_index_error))
    else $error("empty range and index error flagged together");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_index_error |-> out_max_value == '0)
    else $error("index error result carries a nonzero value");

  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_empty_range |->
      (out_max_value == '0) || (out_max_value == rart_pkg::EMPTY_MAX))
    else $error("empty range result carries an unexpected value");

endmodule

bind range_add_range_max_table rart_checker u_rart_checker (.*);

>>> dv/tb_range_add_range_max_table.sv
`timescale 1ns / 1ps
// Self-checking testbench for range_add_range_max_table: directed and random command streams
// against a behavioral copy of the table, with size register changes between phases.
// Depends on rart_pkg and the range_add_range_max_table RTL.
module tb_range_add_range_max_table;

  localparam longint ENTRY_HI = (64'sd1 <<< (rart_pkg::VALUE_BITS - 1)) - 1;
  localparam longint ENTRY_LO = -ENTRY_HI - 1;
  localparam logic [rart_pkg::IDX_BITS-1:0] TOP_INDEX =
    rart_pkg::IDX_BITS'(rart_pkg::MAX_ENTRIES - 1);
  localparam rart_pkg::op_t OP_UNUSED = 2'd3;

  typedef struct {
    rart_pkg::value_t max_value;
    logic             empty_range;
    logic             index_error;
  } table_result_t;

  logic                             clk;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  logic [rart_pkg::OP_BITS-1:0]     in_opcode;
  logic [rart_pkg::IDX_BITS-1:0]    in_low_index;
  logic [rart_pkg::IDX_BITS-1:0]    in_high_index;
  rart_pkg::operand_t               in_operand_value;
  logic                             out_strobe;
  rart_pkg::value_t                 out_max_value;
  logic                             out_empty_range;
  logic                             out_index_error;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [rart_pkg::SIZE_BITS-1:0]   cfg_data;

  // Behavioral copy of the table and its size register.
  rart_pkg::value_t shadow_entries [rart_pkg::MAX_ENTRIES];
  int unsigned      shadow_size;
  table_result_t    pending_results [$];

  int mismatch_count;
  int results_seen;
  int assigns_sent;
  int adds_sent;
  int queries_sent;
  int flagged_sent;
  int size_writes;

  range_add_range_max_table dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_low_index     (in_low_index),
    .in_high_index    (in_high_index),
    .in_operand_value (in_operand_value),
    .out_strobe       (out_strobe),
    .out_max_value    (out_max_value),
    .out_empty_range  (out_empty_range),
    .out_index_error  (out_index_error),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic rart_pkg::value_t add_clamped(rart_pkg::value_t entry,
                                                   rart_pkg::operand_t addend);
    longint sum;
    sum = longint'(entry) + longint'(addend);
    if (sum > ENTRY_HI) sum = ENTRY_HI;
    if (sum < ENTRY_LO) sum = ENTRY_LO;
    return rart_pkg::value_t'(sum);
  endfunction

  // Updates the shadow table for one accepted command and queues the result it must give.
  task automatic apply_table_command(input rart_pkg::op_t op,
                                     input logic [rart_pkg::IDX_BITS-1:0] lo,
                                     input logic [rart_pkg::IDX_BITS-1:0] hi,
                                     input rart_pkg::operand_t val);
    table_result_t    r;
    rart_pkg::value_t best;
    r.max_value   = '0;
    r.empty_range = 1'b0;
    r.index_error = 1'b0;
    case (op)
      rart_pkg::OP_ASSIGN: begin
        assigns_sent++;
        if (lo >= shadow_size) begin
          r.index_error = 1'b1;
        end else begin
          shadow_entries[lo] = rart_pkg::sext_operand(val);
        end
      end
      rart_pkg::OP_ADD, rart_pkg::OP_QUERY: begin
        if (op == rart_pkg::OP_ADD) adds_sent++;
        else queries_sent++;
        // The index check wins over the empty-range check.
        if (lo >= shadow_size || hi >= shadow_size) begin
          r.index_error = 1'b1;
        end else if (lo > hi) begin
          r.empty_range = 1'b1;
          if (op == rart_pkg::OP_QUERY) r.max_value = rart_pkg::EMPTY_MAX;
        end else if (op == rart_pkg::OP_ADD) begin
          for (int i = lo; i <= hi; i++) shadow_entries[i] = add_clamped(shadow_entries[i], val);
        end else begin
          best = rart_pkg::VAL_MIN;
          for (int i = lo; i <= hi; i++) begin
            if (shadow_entries[i] > best) best = shadow_entries[i];
          end
          r.max_value = best;
        end
      end
      default: ;
    endcase
    if (r.index_error || r.empty_range) flagged_sent++;
    pending_results = {pending_results, r};
  endtask

  // Start stays high from one command to the next; only idle_cycles and wait_for_results lower it.
  // Busy only changes at rising edges, so its value at the falling edge holds for the next one.
  task automatic send_command(input rart_pkg::op_t op,
                              input logic [rart_pkg::IDX_BITS-1:0] lo,
                              input logic [rart_pkg::IDX_BITS-1:0] hi,
                              input rart_pkg::operand_t val);
    @(negedge clk);
    start            <= 1'b1;
    in_opcode        <= op;
    in_low_index     <= lo;
    in_high_index    <= hi;
    in_operand_value <= val;
    while (busy) @(negedge clk);
    @(posedge clk);
    apply_table_command(op, lo, hi, val);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic wait_for_results();
    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(input logic [rart_pkg::SIZE_BITS-1:0] data);
    int unsigned v;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    v = data;
    if (v < 1) v = 1;
    if (v > rart_pkg::MAX_ENTRIES) v = rart_pkg::MAX_ENTRIES;
    shadow_size = v;
    size_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing expected, max %0d empty %0b error %0b",
                 $time, out_max_value, out_empty_range, out_index_error);
      end else begin
        want = pending_results.pop_front();
        if (out_max_value !== want.max_value) begin
          mismatch_count++;
          $display("%0t: max_value expected %0d got %0d", $time, want.max_value,
                   out_max_value);
        end
        if (out_empty_range !== want.empty_range) begin
          mismatch_count++;
          $display("%0t: empty_range expected %0b got %0b", $time, want.empty_range,
                   out_empty_range);
        end
        if (out_index_error !== want.index_error) begin
          mismatch_count++;
          $display("%0t: index_error expected %0b got %0b", $time, want.index_error,
                   out_index_error);
        end
      end
    end
  end

  task automatic test_reset_values();
    send_command(rart_pkg::OP_QUERY, '0, TOP_INDEX, '0);
    send_command(rart_pkg::OP_QUERY, 10'd517, 10'd517, '0);
  endtask

  task automatic test_basic_operations();
    send_command(rart_pkg::OP_ASSIGN, '0, '0, 32'sh7FFF_FFFF);
    send_command(rart_pkg::OP_ASSIGN, TOP_INDEX, '0, 32'sh8000_0000);
    send_command(rart_pkg::OP_QUERY, '0, TOP_INDEX, '0);
    send_command(rart_pkg::OP_QUERY, TOP_INDEX, TOP_INDEX, '0);
    send_command(rart_pkg::OP_ADD, 10'd1, TOP_INDEX, 32'sh8000_0000);
    send_command(rart_pkg::OP_QUERY, 10'd512, TOP_INDEX, '0);
    send_command(rart_pkg::OP_ADD, '0, TOP_INDEX, 32'sh7FFF_FFFF);
    send_command(rart_pkg::OP_QUERY, '0, TOP_INDEX, '0);
    send_command(rart_pkg::OP_ADD, 10'd5, 10'd4, 32'sd99);
    send_command(rart_pkg::OP_QUERY, TOP_INDEX, '0, '0);
    send_command(OP_UNUSED, TOP_INDEX, TOP_INDEX, 32'shFFFF_FFFF);
  endtask

  task automatic test_size_register();
    wait_for_results();
    write_size('0);
    send_command(rart_pkg::OP_QUERY, '0, '0, '0);
    send_command(rart_pkg::OP_ASSIGN, 10'd1, '0, 32'sd7);
    send_command(rart_pkg::OP_ADD, 10'd1, '0, 32'sd7);
    wait_for_results();
    write_size(11'd100);
    send_command(rart_pkg::OP_QUERY, 10'd99, 10'd100, '0);
    send_command(rart_pkg::OP_ASSIGN, 10'd100, '0, 32'sd5);
    send_command(rart_pkg::OP_QUERY, '0, 10'd99, '0);
    wait_for_results();
    write_size(11'h7FF);
    send_command(rart_pkg::OP_QUERY, '0, TOP_INDEX, '0);
  endtask

  // Carries entries well past the 32-bit operand range with repeated extreme adds.
  task automatic test_wide_sums();
    wait_for_results();
    write_size(11'd2);
    send_command(rart_pkg::OP_ASSIGN, '0, '0, 32'sh7FFF_FFFF);
    send_command(rart_pkg::OP_ASSIGN, 10'd1, '0, 32'sh8000_0000);
    repeat (16) send_command(rart_pkg::OP_ADD, '0, '0, 32'sh7FFF_FFFF);
    send_command(rart_pkg::OP_QUERY, '0, 10'd1, '0);
    send_command(rart_pkg::OP_ADD, '0, 10'd1, 32'sh7FFF_FFFF);
    send_command(rart_pkg::OP_ADD, '0, 10'd1, -32'sd1);
    send_command(rart_pkg::OP_QUERY, '0, '0, '0);
    send_command(rart_pkg::OP_QUERY, 10'd1, 10'd1, '0);
  endtask

  function automatic rart_pkg::operand_t pick_operand();
    case ($urandom_range(9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return rart_pkg::operand_t'($urandom_range(200)) - 32'sd100;
      default: return rart_pkg::operand_t'($urandom);
    endcase
  endfunction

  task automatic test_random_commands(input int count, input int idle_pct,
                                      input logic [rart_pkg::SIZE_BITS-1:0] size_data);
    rart_pkg::op_t                 op;
    logic [rart_pkg::IDX_BITS-1:0] lo;
    logic [rart_pkg::IDX_BITS-1:0] hi;
    logic [rart_pkg::IDX_BITS-1:0] swap;
    wait_for_results();
    write_size(size_data);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_for_results();
      if ($urandom_range(99) < idle_pct) idle_cycles($urandom_range(1, 70));
      op = rart_pkg::op_t'($urandom_range(2));
      lo = rart_pkg::IDX_BITS'($urandom_range(shadow_size - 1));
      hi = rart_pkg::IDX_BITS'($urandom_range(shadow_size - 1));
      if (lo > hi) begin
        swap = lo;
        lo   = hi;
        hi   = swap;
      end
      // About three commands in sixteen are malformed: unused opcode, wild indices or reversed range.
      case ($urandom_range(15))
        0: op = OP_UNUSED;
        1: begin
          lo = rart_pkg::IDX_BITS'($urandom);
          hi = rart_pkg::IDX_BITS'($urandom);
        end
        2: begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
        default: ;
      endcase
      send_command(op, lo, hi, pick_operand());
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_opcode        = '0;
    in_low_index     = '0;
    in_high_index    = '0;
    in_operand_value = '0;
    cfg_valid        = 1'b0;
    cfg_data         = '0;
    mismatch_count   = 0;
    results_seen     = 0;
    assigns_sent     = 0;
    adds_sent        = 0;
    queries_sent     = 0;
    flagged_sent     = 0;
    size_writes      = 0;
    shadow_size      = rart_pkg::MAX_ENTRIES;
    foreach (shadow_entries[i]) shadow_entries[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_basic_operations();
    test_size_register();
    test_wide_sums();
    test_random_commands(400, 15, 11'd1024);
    test_random_commands(400, 74, 11'($urandom_range(2, 63)));
    test_random_commands(400, 0, 11'h7FF);

    wait_for_results();
    repeat (80) @(posedge clk);
    $display("Ran %0d assigns, %0d range adds and %0d queries (%0d flagged) over %0d size writes;",
             assigns_sent, adds_sent, queries_sent, flagged_sent, size_writes);
    $display("%0d results checked, including sums past 32 bits and full-table ranges.",
             results_seen);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
